FILE: hw/rtl/grid_map_trilinear_interp_assert.svh
// Assertion macros for the grid map interpolator.
// Expects clk and rst in the scope of the module that uses them.
`ifndef GRID_MAP_TRILINEAR_INTERP_ASSERT_SVH
`define GRID_MAP_TRILINEAR_INTERP_ASSERT_SVH
`ifndef SYNTHESIS
`define GMTI_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (rst) prop) \
  else $error("grid map interp: property failed");
`define GMTI_NEVER(lbl, expr) lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
  else $error("grid map interp: forbidden condition seen");
`else
`define GMTI_ASSERT(lbl, prop)
`define GMTI_NEVER(lbl, expr)
`endif
`endif

FILE: hw/rtl/gmti_pkg.sv
// Package for the grid map interpolator: sizes, fixed-point constants, codes, types.
// No dependencies.
package gmti_pkg;

  localparam int MAX_POINTS = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int PTS_W      = IDX_W + 1;
  localparam int N_BANKS    = 8;
  localparam int BANK_AW    = 1 + 3 * (IDX_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 32;

  localparam int FRAC_W = 25;
  localparam int DIFF_W = 34;
  localparam int PROD_W = DIFF_W + FRAC_W;
  localparam int SUM_W  = PROD_W - 23;

  localparam logic signed [DIFF_W-1:0] PI_Q     = 34'sd52707179;
  localparam logic signed [DIFF_W-1:0] TWO_PI_Q = 34'sd105414358;

  typedef enum logic [1:0] {
    FUNC_WR_MAG   = 2'd0,
    FUNC_WR_PHASE = 2'd1,
    FUNC_RD_MAG   = 2'd2,
    FUNC_RD_PHASE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_GRID_POINTS = 2'd0,
    REG_THREE_D     = 2'd1,
    REG_HALF_EXTENT = 2'd2,
    REG_GRID_SCALE  = 2'd3
  } reg_idx_t;

  typedef logic signed [FRAC_W-1:0] frac_t;

  typedef struct packed {
    logic  query;
    logic  phase;
    logic  off;
    frac_t fx;
    frac_t fy;
    frac_t fz;
  } meta_t;

endpackage

FILE: hw/rtl/grid_map_trilinear_interp.sv
// Top level of the grid map interpolator: banked map stores and interpolation pipeline.
// Depends on gmti_pkg and grid_map_trilinear_interp_assert.svh.
//
// Usage:
//   Input stream s_*: tuser carries the function code (write magnitude, write phase,
//   query magnitude, query phase); tdata carries write indices, entry value and the
//   query position. A write beat stores one entry and gives no result. A query beat
//   gives one result beat on m_*: tdata is the interpolated Q8.24 value, tuser the
//   off-grid flag (value zero when set).
//   Configuration: cfg_wr_en with cfg_index and cfg_data writes one register per
//   cycle; write only while the pipeline is empty.
//   Throughput: one beat per cycle while no stall on m_tready holds the pipeline.
//   The eight corners of a query come from eight parity banks (one per x/y/z
//   parity), each with one port, so every query reads all its corners at once.
//   Pipeline: three stages of coordinate arithmetic, one memory read, and three
//   interpolation levels of three stages each (difference, multiply, round).
//   Reset clears the pipeline valid bits and loads the register defaults; map
//   contents are undefined until written.
//   A stall on m_tready freezes the whole pipeline and drops s_tready in the
//   same cycle; nothing is lost or repeated.
`include "grid_map_trilinear_interp_assert.svh"

module grid_map_trilinear_interp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [1:0]                        cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // map_x[4:0] map_y[9:5] map_z[14:10] entry_value[46:15]
  // pos_x[78:47] pos_y[110:79] pos_z[142:111], zero pad [143]
  input  logic [gmti_pkg::IN_DATA_W-1:0]    s_tdata,
  // func[1:0]
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // interp_value[31:0]
  output logic [gmti_pkg::OUT_DATA_W-1:0]   m_tdata,
  // off_grid[0]
  output logic [0:0]                        m_tuser
);
  import gmti_pkg::*;

  function automatic logic signed [DIFF_W-1:0] unwrap_diff(logic signed [31:0] a,
                                                           logic signed [31:0] b,
                                                           logic phase);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(b) - DIFF_W'(a);
    if (phase && d > PI_Q) d = d - TWO_PI_Q;
    if (phase && d < -PI_Q) d = d + TWO_PI_Q;
    return d;
  endfunction

  function automatic logic signed [31:0] lerp_finish(logic signed [31:0] a,
                                                     logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] pr;
    logic signed [PROD_W-25:0] t;
    logic signed [SUM_W-1:0] s;
    // bias negatives so the shift truncates toward zero
    pr = p[PROD_W-1] ? p + $signed(PROD_W'(24'hFFFFFF)) : p;
    t  = pr[PROD_W-1:24];
    s  = SUM_W'(a) + SUM_W'(t);
    if (s > $signed(SUM_W'(32'h7FFFFFFF))) return 32'sh7FFFFFFF;
    if (s < -$signed(SUM_W'(33'h080000000))) return 32'sh80000000;
    return s[31:0];
  endfunction

  // configuration
  logic [5:0]       grid_points;
  logic             three_d;
  logic [30:0]      half_extent;
  logic [31:0]      grid_scale;
  logic [PTS_W-1:0] pts_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_points <= 6'd1;
      three_d     <= 1'b1;
      half_extent <= '0;
      grid_scale  <= '0;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GRID_POINTS: grid_points <= cfg_data[5:0];
        REG_THREE_D:     three_d     <= cfg_data[0];
        REG_HALF_EXTENT: half_extent <= cfg_data[30:0];
        REG_GRID_SCALE:  grid_scale  <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (grid_points == '0) pts_eff = PTS_W'(1);
    else if (int'(grid_points) > MAX_POINTS) pts_eff = PTS_W'(MAX_POINTS);
    else pts_eff = PTS_W'(grid_points);
  end

  // pipeline control
  logic [13:1] v;
  logic        en;
  logic        query3;

  assign en       = !v[13] || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[12:4], v[3] && query3, v[2], v[1], s_tvalid};
    end
  end

  // stage 1: shift position by half extent
  func_t              func1, func2, func3;
  logic [4:0]         wx1, wy1, wz1, wx2, wy2, wz2, wx3, wy3, wz3;
  logic [31:0]        wval1, wval2, wval3;
  logic signed [32:0] sum1 [3];
  logic [31:0]        mag2 [3];
  logic [2:0]         neg2, neg3;
  logic [63:0]        prod3 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      func1 <= func_t'(s_tuser);
      wx1   <= s_tdata[4:0];
      wy1   <= s_tdata[9:5];
      wz1   <= s_tdata[14:10];
      wval1 <= s_tdata[46:15];
      for (int a = 0; a < 3; a++) begin
        sum1[a] <= $signed({s_tdata[47 + 32*a + 31], s_tdata[47 + 32*a +: 32]})
                   + $signed({2'b00, half_extent});
      end
      // stage 2: magnitude and sign
      func2 <= func1;
      wx2 <= wx1; wy2 <= wy1; wz2 <= wz1; wval2 <= wval1;
      for (int a = 0; a < 3; a++) begin
        neg2[a] <= sum1[a][32];
        mag2[a] <= sum1[a][32] ? 32'(-sum1[a]) : sum1[a][31:0];
      end
      // stage 3: scale to grid units
      func3 <= func2;
      wx3 <= wx2; wy3 <= wy2; wz3 <= wz2; wval3 <= wval2;
      neg3 <= neg2;
      for (int a = 0; a < 3; a++) begin
        prod3[a] <= 64'(mag2[a]) * 64'(grid_scale);
      end
    end
  end

  // stage 3 decode: grid index, fraction, neighbour clamp, bank addresses
  logic [IDX_W-1:0]   idx   [3];
  logic [IDX_W-1:0]   nidx  [3];
  frac_t              frac  [3];
  logic [2:0]         ok;
  logic [2:0]         clamp;
  logic [BANK_AW-1:0] maddr [N_BANKS];
  logic [BANK_AW-1:0] waddr;
  logic [2:0]         wbank;
  logic               mem_we;

  assign query3 = func3[1];

  always_comb begin
    logic [31:0]      ip;
    logic [23:0]      fr;
    logic [IDX_W-1:0] sel [3];
    for (int a = 0; a < 3; a++) begin
      ip = prod3[a][63:32];
      fr = prod3[a][31:8];
      if (neg3[a]) begin
        ok[a]   = (ip == '0);
        idx[a]  = '0;
        frac[a] = -frac_t'({1'b0, fr});
      end else begin
        ok[a]   = (ip <= 32'(pts_eff - PTS_W'(1)));
        idx[a]  = ip[IDX_W-1:0];
        frac[a] = frac_t'({1'b0, fr});
      end
    end
    if (!three_d) begin
      ok[2]   = 1'b1;
      idx[2]  = '0;
      frac[2] = '0;
    end
    // in 2D both z corners come from plane z=0
    for (int a = 0; a < 3; a++) begin
      clamp[a] = ({1'b0, idx[a]} == pts_eff - PTS_W'(1)) || (a == 2 && !three_d);
      nidx[a]  = clamp[a] ? idx[a] : idx[a] + IDX_W'(1);
    end
    wbank  = {wz3[0], wy3[0], wx3[0]};
    waddr  = {func3[0], wz3[IDX_W-1:1], wy3[IDX_W-1:1], wx3[IDX_W-1:1]};
    mem_we = v[3] && !query3 && int'(wx3) < MAX_POINTS && int'(wy3) < MAX_POINTS
             && int'(wz3) < MAX_POINTS;
    for (int b = 0; b < N_BANKS; b++) begin
      for (int a = 0; a < 3; a++) begin
        sel[a] = (idx[a][0] == b[a]) ? idx[a] : nidx[a];
      end
      maddr[b] = query3 ? {func3[0], sel[2][IDX_W-1:1], sel[1][IDX_W-1:1], sel[0][IDX_W-1:1]}
                        : waddr;
    end
  end

  // stage 4: banked map stores, registered read
  logic [31:0] rdata [N_BANKS];

  for (genvar b = 0; b < N_BANKS; b++) begin : g_bank
    logic [31:0] mem [BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (en) begin
        if (mem_we && wbank == 3'(b)) mem[maddr[b]] <= wval3;
        rdata[b] <= mem[maddr[b]];
      end
    end
  end

  meta_t      meta [4:13];
  logic [2:0] par4, clamp4;

  always_ff @(posedge clk) begin
    if (en) begin
      meta[4].query <= query3;
      meta[4].phase <= func3[0];
      meta[4].off   <= !(&ok);
      meta[4].fx    <= frac[0];
      meta[4].fy    <= frac[1];
      meta[4].fz    <= frac[2];
      par4   <= {idx[2][0], idx[1][0], idx[0][0]};
      clamp4 <= clamp;
      for (int k = 5; k <= 13; k++) meta[k] <= meta[k-1];
    end
  end

  // stage 5: route corners back from the banks, first-level differences
  logic signed [31:0] corner [8];

  always_comb begin
    logic [2:0] bk;
    for (int c = 0; c < 8; c++) begin
      for (int a = 0; a < 3; a++) begin
        bk[a] = c[a] ? (clamp4[a] ? par4[a] : !par4[a]) : par4[a];
      end
      corner[c] = rdata[bk];
    end
  end

  logic signed [31:0]       a5 [4], a6 [4], r7 [4];
  logic signed [DIFF_W-1:0] d5 [4];
  logic signed [PROD_W-1:0] p6 [4];
  logic signed [31:0]       a8 [2], a9 [2], r10 [2];
  logic signed [DIFF_W-1:0] d8 [2];
  logic signed [PROD_W-1:0] p9 [2];
  logic signed [31:0]       a11, a12, r13;
  logic signed [DIFF_W-1:0] d11;
  logic signed [PROD_W-1:0] p12;
  logic                     off13;

  // corner code is {z, y, x}; first level runs along y
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        a5[i] <= corner[{i[1], 1'b0, i[0]}];
        d5[i] <= unwrap_diff(corner[{i[1], 1'b0, i[0]}], corner[{i[1], 1'b1, i[0]}],
                             meta[4].phase);
        a6[i] <= a5[i];
        p6[i] <= d5[i] * meta[5].fy;
        r7[i] <= lerp_finish(a6[i], p6[i]);
      end
      for (int j = 0; j < 2; j++) begin
        a8[j]  <= r7[2*j];
        d8[j]  <= unwrap_diff(r7[2*j], r7[2*j + 1], meta[7].phase);
        a9[j]  <= a8[j];
        p9[j]  <= d8[j] * meta[8].fx;
        r10[j] <= lerp_finish(a9[j], p9[j]);
      end
      // in 2D the z fraction is zero, so the last level passes the z=0 plane
      a11 <= r10[0];
      d11 <= unwrap_diff(r10[0], r10[1], meta[10].phase);
      a12 <= a11;
      p12 <= d11 * meta[11].fz;
      r13   <= meta[12].off ? 32'sd0 : lerp_finish(a12, p12);
      off13 <= meta[12].off;
    end
  end

  assign m_tvalid   = v[13];
  assign m_tdata    = r13;
  assign m_tuser[0] = off13;

  `GMTI_ASSERT(a_stall_blocks_input, (v[13] && !m_tready) |-> !s_tready)
  `GMTI_NEVER(a_points_nonzero, pts_eff == '0)
  `GMTI_ASSERT(a_result_from_query, v[13] |-> meta[13].query)

endmodule

FILE: bench/tb_grid_map_trilinear_interp.sv
// Self-checking bench for grid_map_trilinear_interp: map writes, magnitude and phase queries.
// Depends on gmti_pkg and the block; fixed-point interpolation is predicted in the bench.
`timescale 1ns / 100ps

module tb_grid_map_trilinear_interp;
  import gmti_pkg::*;

  localparam longint PI_V   = 52707179;
  localparam longint TWOPI_V = 105414358;
  localparam int     LIMIT   = 400000;

  logic clk, rst;
  logic cfg_wr_en;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic s_tvalid, s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid, m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;

  grid_map_trilinear_interp DUT (.*);

  typedef struct {
    func_t f;
    logic [4:0] mx, my, mz;
    logic [31:0] val;
    logic [31:0] px, py, pz;
  } beat_t;

  typedef struct {
    logic [31:0] value;
    logic off;
  } interp_t;

  // bench copies of the maps and registers
  logic [31:0] mag_store [int];
  logic [31:0] phase_store [int];
  int unsigned pts_reg;
  bit three_d_reg;
  logic [30:0] half_reg;
  logic [31:0] scale_reg;

  interp_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int n_sent = 0;
  bit hold_off = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("grid_map_trilinear_interp regression: fail");
      $finish;
    end
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint blend(longint a, longint b, longint fr, bit ph);
    longint d;
    d = b - a;
    if (ph) begin
      if (d > PI_V) d -= TWOPI_V;
      if (d < -PI_V) d += TWOPI_V;
    end
    return sat32(a + (d * fr) / 64'sd16777216);
  endfunction

  function automatic bit grid_coord(logic [31:0] p, int unsigned pts,
                                    output int unsigned ix, output longint fr);
    longint s;
    logic [63:0] m, prod;
    s = longint'($signed(p)) + longint'(half_reg);
    m = (s < 0) ? -s : s;
    prod = m * {32'd0, scale_reg};
    fr = longint'(prod[31:8]);
    ix = 0;
    if (s < 0) begin
      fr = -fr;
      return prod[63:32] == 0;
    end
    if (prod[63:32] > pts - 1) return 0;
    ix = prod[63:32];
    return 1;
  endfunction

  function automatic longint fetch(bit ph, int unsigned x, y, z);
    int a;
    a = (z * 32 + y) * 32 + x;
    if (ph) return phase_store.exists(a) ? longint'($signed(phase_store[a])) : 0;
    return mag_store.exists(a) ? longint'($signed(mag_store[a])) : 0;
  endfunction

  function automatic longint face(bit ph, int unsigned px, nx, py, ny, z,
                                  longint fx, fy);
    longint lo, hi;
    lo = blend(fetch(ph, px, py, z), fetch(ph, px, ny, z), fy, ph);
    hi = blend(fetch(ph, nx, py, z), fetch(ph, nx, ny, z), fy, ph);
    return blend(lo, hi, fx, ph);
  endfunction

  // apply one beat to the bench maps; returns 1 when a result is due
  function automatic bit interpolate(beat_t b, output interp_t r);
    int unsigned pts, px, py, pz, nx, ny, nz;
    longint fx, fy, fz, v;
    bit ok, ph;
    pts = (pts_reg == 0) ? 1 : (pts_reg > 32 ? 32 : pts_reg);
    r = '{32'd0, 1'b1};
    if (b.f == FUNC_WR_MAG || b.f == FUNC_WR_PHASE) begin
      if (b.f == FUNC_WR_MAG) mag_store[(b.mz * 32 + b.my) * 32 + b.mx] = b.val;
      else phase_store[(b.mz * 32 + b.my) * 32 + b.mx] = b.val;
      return 0;
    end
    ph = (b.f == FUNC_RD_PHASE);
    pz = 0; fz = 0;
    ok = grid_coord(b.px, pts, px, fx);
    ok = grid_coord(b.py, pts, py, fy) && ok;
    if (three_d_reg) ok = grid_coord(b.pz, pts, pz, fz) && ok;
    if (!ok) return 1;
    nx = (px + 1 < pts) ? px + 1 : pts - 1;
    ny = (py + 1 < pts) ? py + 1 : pts - 1;
    v = face(ph, px, nx, py, ny, pz, fx, fy);
    if (three_d_reg) begin
      nz = (pz + 1 < pts) ? pz + 1 : pts - 1;
      v = blend(v, face(ph, px, nx, py, ny, nz, fx, fy), fz, ph);
    end
    r = '{v[31:0], 1'b0};
    return 1;
  endfunction

  // result side: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !hold_off && ($urandom_range(0, 9) < 7 || $urandom_range(0, 3) == 0);
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          interp_t e;
          e = pending_results.pop_front();
          if (m_tdata !== e.value) begin
            $error("interp_value expected %h actual %h", e.value, m_tdata);
            errors++;
          end
          if (m_tuser[0] !== e.off) begin
            $error("off_grid expected %0d actual %0d", e.off, m_tuser[0]);
            errors++;
          end
        end
      end
    end
  end

  // hold off the receiver while the sender is busy with queries
  initial begin
    wait (n_sent >= 480);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send(beat_t b);
    interp_t r;
    s_tvalid <= 1'b1;
    s_tuser <= b.f;
    s_tdata <= {1'b0, b.pz, b.py, b.px, b.val, b.mz, b.my, b.mx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
    if (interpolate(b, r)) pending_results.push_back(r);
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_GRID_POINTS: pts_reg = v[5:0];
      REG_THREE_D:     three_d_reg = v[0];
      REG_HALF_EXTENT: half_reg = v[30:0];
      default:         scale_reg = v;
    endcase
  endtask

  task automatic setup(int unsigned pts, bit td, logic [30:0] he, logic [31:0] sc);
    write_reg(REG_GRID_POINTS, pts);
    write_reg(REG_THREE_D, td);
    write_reg(REG_HALF_EXTENT, he);
    write_reg(REG_GRID_SCALE, sc);
  endtask

  // fill an n-point box from index lo on each axis: a cube in 3D, plane z = 0 in 2D
  task automatic fill_maps(int unsigned lo, int unsigned n, bit td);
    beat_t b;
    for (int z = 0; z < (td ? n : 1); z++)
      for (int y = 0; y < n; y++)
        for (int x = 0; x < n; x++)
          for (int k = 0; k < 2; k++) begin
            b.f = k ? FUNC_WR_PHASE : FUNC_WR_MAG;
            b.mx = 5'(lo + x); b.my = 5'(lo + y); b.mz = td ? 5'(lo + z) : 5'd0;
            case ($urandom_range(0, 5))
              0: b.val = 32'h7fffffff;
              1: b.val = 32'h80000000;
              2: b.val = $urandom_range(0, 2 * TWOPI_V) - TWOPI_V;
              default: b.val = $urandom;
            endcase
            b.px = 0; b.py = 0; b.pz = 0;
            send(b);
          end
  endtask

  function automatic logic [31:0] rand_pos(int unsigned pts);
    // mostly within the lattice, sometimes just outside or anywhere
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return -($urandom_range(1, 65535));
      default: return $urandom_range(0, pts * 65536 + 65535);
    endcase
  endfunction

  // from one point below the half extent up to span - 1 points above it
  function automatic logic [31:0] near_pos(int unsigned span);
    return 32'($urandom_range(0, span * 65536)) - 32'd65536;
  endfunction

  typedef struct {
    beat_t b;
    bit known;
    interp_t r;
  } row_t;

  row_t directed[$];

  initial begin
    beat_t b;
    int unsigned pts;
    cfg_wr_en = 0; cfg_index = REG_GRID_POINTS; cfg_data = 0;
    s_tvalid = 0; s_tdata = '0; s_tuser = FUNC_WR_MAG;
    rst = 1;
    pts_reg = 1; three_d_reg = 1; half_reg = 0; scale_reg = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: after reset, one point, scale 0 so every position maps to index 0
    b = '{FUNC_WR_MAG, 5'd0, 5'd0, 5'd0, 32'h0123_4567, 32'd0, 32'd0, 32'd0};
    directed.push_back('{b, 0, '{0, 0}});
    b.f = FUNC_WR_PHASE; b.val = 32'h8000_0000;
    directed.push_back('{b, 0, '{0, 0}});
    b.f = FUNC_WR_MAG; b.mx = 31; b.my = 31; b.mz = 31; b.val = 32'h7fff_ffff;
    directed.push_back('{b, 0, '{0, 0}});
    b = '{FUNC_RD_MAG, 0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'd0};
    directed.push_back('{b, 1, '{32'h0123_4567, 0}});
    b.f = FUNC_RD_PHASE;
    directed.push_back('{b, 1, '{32'h8000_0000, 0}});
    foreach (directed[i]) begin
      send(directed[i].b);
      if (directed[i].known) pending_results[$] = directed[i].r;
    end
    drain();

    // directed: a small 3D grid, negative fraction, clamp, off lattice, extremes
    setup(3, 1, 31'd65536, 32'h0001_0000);
    fill_maps(0, 3, 1);
    for (int i = 0; i < 20; i++) begin
      b.f = i[0] ? FUNC_RD_PHASE : FUNC_RD_MAG;
      b.mx = $urandom; b.my = $urandom; b.mz = $urandom; b.val = $urandom;
      b.px = (i < 4) ? -(32'd98304) : (i < 8) ? 32'd65536 * 2 - 1 : rand_pos(2);
      b.py = (i == 9) ? 32'h7fff_ffff : rand_pos(2);
      b.pz = (i == 10) ? 32'h8000_0000 : rand_pos(2);
      send(b);
    end
    drain();

    // random phases over several settings, extremes among them
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: setup(0, 0, 31'h7fff_ffff, 32'hffff_ffff);
        1: setup(63, 0, 31'd65536 * 28, 32'h0001_0000);
        2: setup(32, 1, 31'd65536 * 30, 32'h0001_0000);
        3: setup(2, 1, 31'd65536, 32'h0000_8000);
        default: setup($urandom_range(1, 6), $urandom_range(0, 1),
                       $urandom_range(0, 65536 * 4), $urandom_range(4096, 131072));
      endcase
      pts = (pts_reg == 0) ? 1 : (pts_reg > 32 ? 32 : pts_reg);
      // fill every entry a query can reach; the large grids only near the far corner
      case (ph)
        1: fill_maps(27, 5, 0);
        2: fill_maps(29, 3, 1);
        default: fill_maps(0, pts, three_d_reg);
      endcase
      for (int i = 0; i < 140; i++) begin
        b.f = func_t'($urandom_range(2, 3));
        // writes land on the plane or cube in use
        if ($urandom_range(0, 4) == 0) begin
          b.f = func_t'($urandom_range(0, 1));
          b.mx = $urandom_range(0, pts - 1); b.my = $urandom_range(0, pts - 1);
          b.mz = three_d_reg ? $urandom_range(0, pts - 1) : 0;
        end else begin
          b.mx = $urandom; b.my = $urandom; b.mz = $urandom;
        end
        b.val = $urandom;
        b.px = rand_pos(pts); b.py = rand_pos(pts); b.pz = rand_pos(pts);
        if (ph == 0) begin
          b.px = $urandom; b.py = $urandom; b.pz = $urandom;
        end else if (ph == 1 || ph == 2) begin
          b.px = near_pos(ph == 1 ? 6 : 4);
          b.py = near_pos(ph == 1 ? 6 : 4);
          b.pz = near_pos(ph == 1 ? 6 : 4);
        end
        send(b);
      end
      // sender waits here until every result is back
      drain();
    end

    if (errors == 0) begin
      $display("grid_map_trilinear_interp regression: pass");
    end else begin
      $display("grid_map_trilinear_interp regression: fail");
    end
    $finish;
  end

endmodule
